// ===== rtl/wht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water heater thermostat package
// Request and result types, configuration register map and shared constants.
// ----------------------------------------------------------------------------
package wht_pkg;

  // Request kinds carried in req_type
  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqPower = 2'd1,
    ReqUp    = 2'd2,
    ReqDown  = 2'd3
  } req_type_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTicksPerSample = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInitialSp      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpMin          = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpMax          = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSpStep         = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBand           = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSettingTimeout = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgBlinkPeriod    = 3'd7;

  // Register reset values
  localparam logic [15:0] RstTicksPerSample = 16'd1;
  localparam logic [7:0]  RstSetpoint       = 8'd60;
  localparam logic [7:0]  RstSpMin          = 8'd35;
  localparam logic [7:0]  RstSpMax          = 8'd75;
  localparam logic [4:0]  RstSpStep         = 5'd5;
  localparam logic [4:0]  RstBand           = 5'd5;
  localparam logic [7:0]  RstSettingTimeout = 8'd50;
  localparam logic [7:0]  RstBlinkPeriod    = 8'd10;

  // LED behavior codes
  localparam logic [1:0] LedOff    = 2'd0;
  localparam logic [1:0] LedSteady = 2'd1;
  localparam logic [1:0] LedBlink  = 2'd2;

  // Samples per average, and the reciprocal used for the divide by ten:
  // floor(x * 3277 / 2^15) == floor(x / 10) for every x below 16384.
  localparam logic [3:0]  SamplesPerAvg = 4'd10;
  localparam logic [11:0] DivTenMul     = 12'd3277;
  localparam int unsigned DivTenShift   = 15;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] sensor_sample;
  } wht_req_t;

  typedef struct packed {
    logic       heater_on;
    logic       cooler_on;
    logic       heater_led;
    logic       display_enable;
    logic [7:0] display_value;
    logic       setting_mode;
    logic       power_on;
    logic [7:0] setpoint_value;
    logic       save_strobe;
  } wht_res_t;

  typedef struct packed {
    logic [15:0] ticks_per_sample;
    logic [7:0]  setpoint_min;
    logic [7:0]  setpoint_max;
    logic [4:0]  setpoint_step;
    logic [4:0]  band;
    logic [7:0]  setting_timeout;
    logic [7:0]  blink_period;
  } wht_cfg_t;

  // Setpoint load issued by a write of the initial setpoint register
  typedef struct packed {
    logic       load;
    logic [6:0] value;
  } wht_sp_load_t;

endpackage

// ===== rtl/wht_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// Decodes the write port into the register file and the setpoint load.
// ----------------------------------------------------------------------------
module wht_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wht_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output wht_pkg::wht_cfg_t             cfg_o,
  output wht_pkg::wht_sp_load_t         sp_load_o
);
  import wht_pkg::*;

  wht_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_sample <= RstTicksPerSample;
      cfg_q.setpoint_min     <= RstSpMin;
      cfg_q.setpoint_max     <= RstSpMax;
      cfg_q.setpoint_step    <= RstSpStep;
      cfg_q.band             <= RstBand;
      cfg_q.setting_timeout  <= RstSettingTimeout;
      cfg_q.blink_period     <= RstBlinkPeriod;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTicksPerSample: cfg_q.ticks_per_sample <= cfg_wdata_i;
        CfgSpMin:          cfg_q.setpoint_min     <= cfg_wdata_i[7:0];
        CfgSpMax:          cfg_q.setpoint_max     <= cfg_wdata_i[7:0];
        CfgSpStep:         cfg_q.setpoint_step    <= cfg_wdata_i[4:0];
        CfgBand:           cfg_q.band             <= cfg_wdata_i[4:0];
        CfgSettingTimeout: cfg_q.setting_timeout  <= cfg_wdata_i[7:0];
        CfgBlinkPeriod:    cfg_q.blink_period     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o           = cfg_q;
  // The initial setpoint is not kept; a write loads the live setpoint
  assign sp_load_o.load  = cfg_we_i && (cfg_idx_i == CfgInitialSp);
  assign sp_load_o.value = cfg_wdata_i[6:0];

endmodule

// ===== rtl/wht_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat core
// Holds the controller state and computes the next state and result for one
// request in a single pass.
// ----------------------------------------------------------------------------
module wht_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  wht_pkg::wht_req_t      req_i,
  input  wht_pkg::wht_cfg_t      cfg_i,
  input  wht_pkg::wht_sp_load_t  sp_load_i,
  output wht_pkg::wht_res_t      res_o
);
  import wht_pkg::*;

  logic        power_q, power_d;
  logic        adjust_q, adjust_d;
  logic [7:0]  sp_q, sp_d;
  logic [7:0]  last_q, last_d;
  logic [11:0] sum_q, sum_d;
  logic [7:0]  avg_q, avg_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  idle_q, idle_d;
  logic [7:0]  dblink_q, dblink_d;
  logic [7:0]  lblink_q, lblink_d;
  logic        disp_lit_q, disp_lit_d;
  logic [1:0]  led_mode_q, led_mode_d;
  logic        led_lit_q, led_lit_d;
  logic        heat_q, heat_d;
  logic        cool_q, cool_d;
  logic        strobe;

  // Effective periods: zero acts as one
  logic [15:0] tps_eff;
  logic [7:0]  to_eff, blink_eff;

  // Sample path values
  logic [15:0] tick_inc;
  logic [11:0] sum_add;
  logic [3:0]  cnt_add;
  logic [23:0] avg_prod;
  logic [7:0]  idle_s, dblink_s, lblink_s;

  // Step path values
  logic [8:0]  up_sum;
  logic [8:0]  dn_diff;
  logic [7:0]  sp_up, sp_dn;

  // Hysteresis thresholds
  logic        lo_ok;
  logic [7:0]  lo_thr;
  logic [8:0]  hi_thr;

  always_comb begin
    tps_eff   = (cfg_i.ticks_per_sample == '0) ? 16'd1 : cfg_i.ticks_per_sample;
    to_eff    = (cfg_i.setting_timeout == '0) ? 8'd1 : cfg_i.setting_timeout;
    blink_eff = (cfg_i.blink_period == '0) ? 8'd1 : cfg_i.blink_period;

    tick_inc = tick_q + 16'd1;
    sum_add  = sum_q + {4'd0, req_i.sensor_sample};
    cnt_add  = cnt_q + 4'd1;
    avg_prod = {12'd0, sum_add} * {12'd0, DivTenMul};
    idle_s   = adjust_q ? idle_q + 8'd1 : idle_q;
    dblink_s = (power_q && adjust_q) ? dblink_q + 8'd1 : dblink_q;
    lblink_s = (led_mode_q == LedBlink) ? lblink_q + 8'd1 : lblink_q;

    up_sum  = {1'b0, sp_q} + {4'd0, cfg_i.setpoint_step};
    sp_up   = (up_sum > {1'b0, cfg_i.setpoint_max}) ? cfg_i.setpoint_max : up_sum[7:0];
    dn_diff = {1'b0, sp_q} - {4'd0, cfg_i.setpoint_step};
    sp_dn   = (dn_diff[8] || (dn_diff[7:0] < cfg_i.setpoint_min)) ?
              cfg_i.setpoint_min : dn_diff[7:0];

    power_d    = power_q;
    adjust_d   = adjust_q;
    sp_d       = sp_q;
    last_d     = last_q;
    sum_d      = sum_q;
    avg_d      = avg_q;
    tick_d     = tick_q;
    cnt_d      = cnt_q;
    idle_d     = idle_q;
    dblink_d   = dblink_q;
    lblink_d   = lblink_q;
    disp_lit_d = disp_lit_q;
    led_mode_d = led_mode_q;
    led_lit_d  = led_lit_q;
    heat_d     = heat_q;
    cool_d     = cool_q;
    strobe     = 1'b0;

    case (req_i.req_type)
      ReqTick: begin
        if (tick_inc >= tps_eff) begin
          tick_d   = '0;
          last_d   = req_i.sensor_sample;
          sum_d    = sum_add;
          cnt_d    = cnt_add;
          if (cnt_add >= SamplesPerAvg) begin
            avg_d = avg_prod[DivTenShift +: 8];
            sum_d = '0;
            cnt_d = '0;
          end
          idle_d   = idle_s;
          dblink_d = dblink_s;
          lblink_d = lblink_s;
          if (dblink_s >= blink_eff) begin
            disp_lit_d = ~disp_lit_q;
            dblink_d   = '0;
          end
          if (lblink_s >= blink_eff) begin
            led_lit_d = ~led_lit_q;
            lblink_d  = '0;
          end
          if (adjust_q && (idle_s >= to_eff)) begin
            adjust_d = 1'b0;
            idle_d   = '0;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      ReqPower: power_d = ~power_q;
      ReqUp, ReqDown: begin
        if (!adjust_q) begin
          adjust_d = 1'b1;
        end else begin
          idle_d = '0;
          strobe = 1'b1;
          sp_d   = (req_i.req_type == ReqUp) ? sp_up : sp_dn;
        end
      end
      default: ;
    endcase

    // Hysteresis evaluation on the updated state
    lo_ok  = sp_d >= {3'd0, cfg_i.band};
    lo_thr = sp_d - {3'd0, cfg_i.band};
    hi_thr = {1'b0, sp_d} + {4'd0, cfg_i.band};

    if (!power_d) begin
      heat_d     = 1'b0;
      cool_d     = 1'b0;
      led_lit_d  = 1'b0;
      led_mode_d = LedOff;
      disp_lit_d = 1'b0;
    end else begin
      if (lo_ok && (avg_d <= lo_thr)) begin
        heat_d     = 1'b1;
        cool_d     = 1'b0;
        led_mode_d = LedBlink;
      end else if ({1'b0, avg_d} >= hi_thr) begin
        heat_d     = 1'b0;
        cool_d     = 1'b1;
        led_lit_d  = 1'b1;
        led_mode_d = LedSteady;
      end
      if (!adjust_d) begin
        disp_lit_d = 1'b1;
      end
    end

    res_o.heater_on      = heat_d;
    res_o.cooler_on      = cool_d;
    res_o.heater_led     = led_lit_d;
    res_o.display_enable = disp_lit_d;
    res_o.display_value  = !power_d ? 8'd0 : (adjust_d ? sp_d : last_d);
    res_o.setting_mode   = adjust_d;
    res_o.power_on       = power_d;
    res_o.setpoint_value = sp_d;
    res_o.save_strobe    = strobe;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q    <= 1'b0;
      adjust_q   <= 1'b0;
      sp_q       <= RstSetpoint;
      last_q     <= '0;
      sum_q      <= '0;
      avg_q      <= '0;
      tick_q     <= '0;
      cnt_q      <= '0;
      idle_q     <= '0;
      dblink_q   <= '0;
      lblink_q   <= '0;
      disp_lit_q <= 1'b0;
      led_mode_q <= LedOff;
      led_lit_q  <= 1'b0;
      heat_q     <= 1'b0;
      cool_q     <= 1'b0;
    end else if (sp_load_i.load) begin
      sp_q <= {1'b0, sp_load_i.value};
    end else if (fire_i) begin
      power_q    <= power_d;
      adjust_q   <= adjust_d;
      sp_q       <= sp_d;
      last_q     <= last_d;
      sum_q      <= sum_d;
      avg_q      <= avg_d;
      tick_q     <= tick_d;
      cnt_q      <= cnt_d;
      idle_q     <= idle_d;
      dblink_q   <= dblink_d;
      lblink_q   <= lblink_d;
      disp_lit_q <= disp_lit_d;
      led_mode_q <= led_mode_d;
      led_lit_q  <= led_lit_d;
      heat_q     <= heat_d;
      cool_q     <= cool_d;
    end
  end

endmodule

// ===== rtl/water_heater_thermostat_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water heater thermostat unit
// Hysteresis thermostat for a heater and a cooler with sample averaging,
// setpoint adjustment, display and LED blinking.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-------------------------
//  request  | in        | in_valid_i / in_stall_o | in_req_i  (wht_req_t)
//  result   | out       | out_valid_o / out_stall_i | out_res_o (wht_res_t)
//  config   | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  An accepted request is loaded into the input register, and the edge on
//  which it fires writes the state update into the result register. One
//  request per cycle is sustained while the result is not stalled; the
//  single-pass state update of the core sets that rate.
//  Reset clears the valid flags and the core state, loads the setpoint with 60
//  and the registers with their defaults. A stalled result holds the request
//  in the input register; the input stalls only when both registers are full.
//
module water_heater_thermostat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wht_pkg::wht_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wht_pkg::wht_res_t             out_res_o,
  input  logic                          cfg_we_i,
  input  logic [wht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wht_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import wht_pkg::*;

  logic         in_vld_q;
  wht_req_t     in_q;
  logic         out_vld_q;
  wht_res_t     out_q;
  logic         in_accept;
  logic         fire;
  wht_res_t     res_d;
  wht_cfg_t     cfg;
  wht_sp_load_t sp_load;

  // Process the held request whenever the result register is free or drains
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  wht_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .sp_load_o   (sp_load)
  );

  wht_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .req_i     (in_q),
    .cfg_i     (cfg),
    .sp_load_i (sp_load),
    .res_o     (res_d)
  );

  // Valid flags of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture a new request, hold a stalled result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule
